// ----- src/orl_pkg.sv -----
// Shared types and sizing constants for the ordered record list.
package orl_pkg;

  localparam int CAPACITY     = 16;
  localparam int PAYLOAD_BITS = 32;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  typedef enum logic [2:0] {
    CMD_INS_FRONT  = 3'd0,
    CMD_INS_BACK   = 3'd1,
    CMD_INS_SORTED = 3'd2,
    CMD_RM_FRONT   = 3'd3,
    CMD_RM_BACK    = 3'd4,
    CMD_RM_KEY     = 3'd5,
    CMD_READ_POS   = 3'd6,
    CMD_READ_KEY   = 3'd7
  } cmd_t;

  typedef logic signed [31:0]       key_t;
  typedef logic [PAYLOAD_BITS-1:0]  pay_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // broadcast to every cell when an item is accepted
  typedef struct packed {
    cmd_t       cmd;
    key_t       key;
    logic [4:0] position;
    cnt_t       count;
  } cell_ctl_t;

  // broadcast to every cell in the update cycle
  typedef struct packed {
    logic ins;
    logic rmv;
    key_t key;
    pay_t payload;
  } cell_act_t;

endpackage

// ----- src/orl_if.sv -----
// Command and result channel interfaces of the ordered record list.
interface orl_req_if import orl_pkg::*; ();
  logic        valid;
  logic        ready;
  cmd_t        cmd;
  key_t        rec_key;
  logic [31:0] rec_payload;
  logic [4:0]  position;

  modport source(output valid, cmd, rec_key, rec_payload, position, input ready);
  modport sink(input valid, cmd, rec_key, rec_payload, position, output ready);
endinterface

interface orl_rsp_if import orl_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        ok;
  key_t        out_key;
  logic [31:0] out_payload;
  logic [4:0]  entry_count;
  logic        is_empty;

  modport source(output valid, ok, out_key, out_payload, entry_count, is_empty, input ready);
  modport sink(input valid, ok, out_key, out_payload, entry_count, is_empty, output ready);
endinterface

// ----- src/orl_cell.sv -----
// One list cell: holds a record, marks itself on compare and shifts with its neighbours.
module orl_cell import orl_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  input  cell_ctl_t        ctl,
  input  logic             capture,
  input  cell_act_t        act,
  input  key_t             left_key,
  input  pay_t             left_pay,
  input  key_t             right_key,
  input  pay_t             right_pay,
  input  logic             prev_past,
  output logic             past,
  output logic             first,
  output key_t             key,
  output pay_t             payload
);

  logic mark;
  logic mark_next;
  logic live;
  logic at_back;
  logic pos_hit;

  assign live    = CNT_W'(idx) < ctl.count;
  assign at_back = CNT_W'(idx) == ctl.count;
  assign pos_hit = CMP_W'(ctl.position) == (CMP_W'(idx) + CMP_W'(1));

  always_comb begin
    case (ctl.cmd)
      CMD_INS_FRONT:  mark_next = (idx == '0);
      CMD_INS_BACK:   mark_next = at_back;
      CMD_INS_SORTED: mark_next = !(live && (key < ctl.key));
      CMD_RM_FRONT:   mark_next = live && (idx == '0);
      CMD_RM_BACK:    mark_next = 1'b0;
      CMD_RM_KEY:     mark_next = live && (key == ctl.key);
      CMD_READ_POS:   mark_next = live && pos_hit;
      CMD_READ_KEY:   mark_next = live && (key == ctl.key);
      default:        mark_next = 1'b0;
    endcase
  end

  assign past  = prev_past | mark;
  assign first = mark & ~prev_past;

  always_ff @(posedge clk) begin
    if (capture) begin
      mark <= mark_next;
    end
    if (act.ins && past) begin
      key     <= first ? act.key : left_key;
      payload <= first ? act.payload : left_pay;
    end else if (act.rmv && past) begin
      key     <= right_key;
      payload <= right_pay;
    end
  end

endmodule

// ----- src/ordered_record_list.sv -----
// Top level of the ordered record list: command handling, cell chain and result register.
// Bounded ordered list of CAPACITY records held in a row of cells, entry 0 at the front.
// Handling a command: in the cycle it is accepted every cell compares its stored key
// with the command in parallel and registers a mark; then, in the apply state, the first
// marked cell is resolved along the chain, the cells shift one place toward the back
// (insert) or the front (removal from the front or by key) and the result is written to
// the output register. A new command is accepted while a result waits to be taken; the
// update cycle holds until the output register is free. No clearing pass follows reset:
// only live entries are ever read.
module ordered_record_list import orl_pkg::*; (
  input logic    clk,
  input logic    rst,
  orl_req_if.sink   req,
  orl_rsp_if.source rsp
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_APPLY = 2'b10
  } state_t;

  state_t state;
  cnt_t   count;
  cmd_t   cmd_r;
  key_t   key_r;
  pay_t   pay_r;

  logic        out_valid;
  logic        out_ok;
  key_t        out_key_r;
  logic [31:0] out_pay_r;
  cnt_t        out_count;

  logic      accept;
  logic      slot_free;
  logic      complete;
  logic      full;
  logic      is_ins;
  logic      is_read;
  logic      found;
  logic      ok_next;
  cnt_t      count_next;
  key_t      rd_key;
  pay_t      rd_pay;
  cell_ctl_t ctl;
  cell_act_t act;

  logic past  [CAPACITY];
  logic first [CAPACITY];
  key_t key_a [CAPACITY];
  pay_t pay_a [CAPACITY];

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign slot_free = !out_valid || rsp.ready;
  assign complete  = (state == S_APPLY) && slot_free;
  assign full      = (count == CNT_W'(CAPACITY));
  assign is_ins    = (cmd_r == CMD_INS_FRONT) || (cmd_r == CMD_INS_BACK) ||
                     (cmd_r == CMD_INS_SORTED);
  assign is_read   = (cmd_r == CMD_READ_POS) || (cmd_r == CMD_READ_KEY);
  assign found     = past[CAPACITY-1];

  assign ctl = '{cmd: req.cmd, key: req.rec_key, position: req.position, count: count};

  assign act.ins     = complete && is_ins && !full;
  assign act.rmv     = complete && ((cmd_r == CMD_RM_FRONT) || (cmd_r == CMD_RM_KEY));
  assign act.key     = key_r;
  assign act.payload = pay_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    orl_cell u_cell (
      .clk      (clk),
      .idx      (IDX_W'(i)),
      .ctl      (ctl),
      .capture  (accept),
      .act      (act),
      .left_key (key_a[(i == 0) ? 0 : i - 1]),
      .left_pay (pay_a[(i == 0) ? 0 : i - 1]),
      .right_key(key_a[(i == CAPACITY - 1) ? i : i + 1]),
      .right_pay(pay_a[(i == CAPACITY - 1) ? i : i + 1]),
      .prev_past((i == 0) ? 1'b0 : past[(i == 0) ? 0 : i - 1]),
      .past     (past[i]),
      .first    (first[i]),
      .key      (key_a[i]),
      .payload  (pay_a[i])
    );
  end

  always_comb begin
    rd_key = '0;
    rd_pay = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        rd_key = rd_key | key_a[i];
        rd_pay = rd_pay | pay_a[i];
      end
    end
  end

  always_comb begin
    ok_next    = 1'b0;
    count_next = count;
    case (cmd_r)
      CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_SORTED: begin
        ok_next = !full;
        if (!full) count_next = count + CNT_W'(1);
      end
      CMD_RM_FRONT, CMD_RM_BACK: begin
        ok_next = (count != '0);
        if (count != '0) count_next = count - CNT_W'(1);
      end
      CMD_RM_KEY: begin
        ok_next = found;
        if (found) count_next = count - CNT_W'(1);
      end
      CMD_READ_POS, CMD_READ_KEY: begin
        ok_next = found;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (complete) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) state <= S_APPLY;
        end
        S_APPLY: begin
          if (slot_free) begin
            state <= S_IDLE;
            count <= count_next;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= req.cmd;
      key_r <= req.rec_key;
      pay_r <= PAYLOAD_BITS'(req.rec_payload);
    end
    if (complete) begin
      out_ok    <= ok_next;
      out_key_r <= (is_read && ok_next) ? rd_key : '0;
      out_pay_r <= (is_read && ok_next) ? 32'(rd_pay) : '0;
      out_count <= count_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.ok          = out_ok;
  assign rsp.out_key     = out_key_r;
  assign rsp.out_payload = out_pay_r;
  assign rsp.entry_count = 5'(out_count);
  assign rsp.is_empty    = (out_count == '0);

endmodule

// ----- src/orl_checker.sv -----
// Port-level checks for the ordered record list, bound to the top level.
module orl_checker import orl_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        ok,
  input key_t        out_key,
  input logic [31:0] out_payload,
  input logic [4:0]  entry_count,
  input logic        is_empty
);

  logic [1:0] pending;
  logic       req_fire;
  logic       rsp_fire;

  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(req_fire) - 2'(rsp_fire);
    end
  end

  // no result without an accepted item behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    rsp_fire |-> pending != 2'd0)
    else $error("result delivered with no item outstanding");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (is_empty == (entry_count == 5'd0)))
    else $error("empty flag disagrees with entry count");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !ok) |-> (out_key == '0 && out_payload == '0))
    else $error("failed item carries a record");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(ok) && $stable(out_key) && $stable(entry_count)))
    else $error("stalled result changed");

endmodule

bind ordered_record_list orl_checker u_orl_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .ok         (rsp.ok),
  .out_key    (rsp.out_key),
  .out_payload(rsp.out_payload),
  .entry_count(rsp.entry_count),
  .is_empty   (rsp.is_empty)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the ordered record list: commands in, results checked in order.
module tb import orl_pkg::*; ();

  typedef struct {
    cmd_t        cmd;
    key_t        key;
    logic [31:0] payload;
    logic [4:0]  position;
  } list_cmd_t;

  typedef struct {
    logic        ok;
    key_t        key;
    logic [31:0] payload;
    logic [4:0]  count;
    logic        empty;
  } list_result_t;

  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 80;
  localparam int CALM_FROM     = 700;
  localparam int CALM_TO       = 900;
  localparam int WATCHDOG_MAX  = 5000;
  localparam int DRAIN_CYCLES  = 10;

  logic clk;
  logic rst;

  orl_req_if req ();
  orl_rsp_if rsp ();

  ordered_record_list dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  list_cmd_t    pending_cmds[$];
  list_result_t expected_results[$];
  list_cmd_t    cur_cmd;

  key_t lst_key[CAPACITY];
  pay_t lst_pay[CAPACITY];
  int   lst_len;

  int   queued_n;
  int   sent_n;
  int   got_n;
  int   errors;
  logic calm;

  assign calm = (sent_n >= CALM_FROM) && (sent_n < CALM_TO);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // golden list: applies one command and queues the result it should give
  task automatic list_apply(input list_cmd_t c);
    list_result_t r;
    int at;
    bit hit;
    r = '{default: '0};
    at = 0;
    hit = 1'b0;
    case (c.cmd)
      CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_SORTED: begin
        if (lst_len < CAPACITY) begin
          if (c.cmd == CMD_INS_BACK) begin
            at = lst_len;
          end else if (c.cmd == CMD_INS_SORTED) begin
            while (at < lst_len && lst_key[at] < c.key) at++;
          end
          for (int i = lst_len; i > at; i--) begin
            lst_key[i] = lst_key[i-1];
            lst_pay[i] = lst_pay[i-1];
          end
          lst_key[at] = c.key;
          lst_pay[at] = c.payload[PAYLOAD_BITS-1:0];
          lst_len++;
          r.ok = 1'b1;
        end
      end
      CMD_RM_FRONT, CMD_RM_BACK, CMD_RM_KEY: begin
        if (c.cmd == CMD_RM_KEY) begin
          for (int i = 0; i < lst_len; i++) begin
            if (!hit && lst_key[i] == c.key) begin
              hit = 1'b1;
              at = i;
            end
          end
        end else begin
          hit = (lst_len > 0);
          at = (c.cmd == CMD_RM_BACK) ? lst_len - 1 : 0;
        end
        if (hit) begin
          for (int i = at; i + 1 < lst_len; i++) begin
            lst_key[i] = lst_key[i+1];
            lst_pay[i] = lst_pay[i+1];
          end
          lst_len--;
          r.ok = 1'b1;
        end
      end
      CMD_READ_POS: begin
        if (c.position >= 1 && c.position <= lst_len) begin
          r.ok = 1'b1;
          r.key = lst_key[c.position - 1];
          r.payload = lst_pay[c.position - 1];
        end
      end
      CMD_READ_KEY: begin
        for (int i = 0; i < lst_len; i++) begin
          if (!hit && lst_key[i] == c.key) begin
            hit = 1'b1;
            r.ok = 1'b1;
            r.key = lst_key[i];
            r.payload = lst_pay[i];
          end
        end
      end
      default: ;
    endcase
    r.count = 5'(lst_len);
    r.empty = (lst_len == 0);
    expected_results.push_back(r);
  endtask

  task automatic queue_cmd(input cmd_t cmd, input key_t key, input logic [31:0] payload,
                           input logic [4:0] position);
    list_cmd_t c;
    c.cmd = cmd;
    c.key = key;
    c.payload = payload;
    c.position = position;
    pending_cmds.push_back(c);
    queued_n++;
  endtask

  task automatic wait_drained();
    while (sent_n != queued_n || expected_results.size() != 0) @(posedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        list_apply(cur_cmd);
        sent_n++;
      end
      if (!req.valid || req.ready) begin
        if (pending_cmds.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
          cur_cmd = pending_cmds.pop_front();
          req.valid       <= 1'b1;
          req.cmd         <= cur_cmd.cmd;
          req.rec_key     <= cur_cmd.key;
          req.rec_payload <= cur_cmd.payload;
          req.position    <= cur_cmd.position;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  int  hold_left;
  bit  hold_done;
  list_result_t want;

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got_n++;
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected");
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (rsp.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, rsp.ok);
            errors++;
          end
          if (rsp.out_key !== want.key) begin
            $error("out_key: expected %0d, got %0d", want.key, rsp.out_key);
            errors++;
          end
          if (rsp.out_payload !== want.payload) begin
            $error("out_payload: expected %08h, got %08h", want.payload, rsp.out_payload);
            errors++;
          end
          if (rsp.entry_count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, rsp.entry_count);
            errors++;
          end
          if (rsp.is_empty !== want.empty) begin
            $error("is_empty: expected %0d, got %0d", want.empty, rsp.is_empty);
            errors++;
          end
        end
      end
      if (!hold_done && got_n >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= calm || ($urandom_range(0, 99) >= 10);
      end
    end
  end

  // stall watchdog
  int quiet_cycles;

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  key_t      key_pool[12];
  list_cmd_t c;
  int        ins_pct;
  int        roll;

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.cmd = CMD_INS_FRONT;
    req.rec_key = '0;
    req.rec_payload = '0;
    req.position = '0;
    rsp.ready = 1'b0;
    lst_len = 0;
    queued_n = 0;
    sent_n = 0;
    got_n = 0;
    errors = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty list
    queue_cmd(CMD_RM_FRONT, 0, 0, 0);
    queue_cmd(CMD_RM_BACK, 0, 0, 0);
    queue_cmd(CMD_RM_KEY, 7, 0, 0);
    queue_cmd(CMD_READ_POS, 0, 0, 0);
    // fill to capacity, extremes and duplicate keys among them
    queue_cmd(CMD_INS_FRONT, 32'sh8000_0000, 32'hFFFF_FFFF, 0);
    queue_cmd(CMD_INS_BACK, 32'sh7FFF_FFFF, 32'h0000_0000, 0);
    queue_cmd(CMD_INS_SORTED, 0, 32'h1, 0);
    queue_cmd(CMD_INS_SORTED, 0, 32'h2, 0);
    queue_cmd(CMD_INS_SORTED, -1, 32'h3, 0);
    queue_cmd(CMD_INS_SORTED, 1, 32'h4, 0);
    for (int i = 0; i < 10; i++)
      queue_cmd(cmd_t'(i % 3), i * 7 - 30, $urandom(), 0);
    queue_cmd(CMD_INS_SORTED, 5, 32'hDEAD_BEEF, 0);
    queue_cmd(CMD_INS_BACK, 5, 32'hDEAD_BEEF, 0);
    queue_cmd(CMD_READ_POS, 0, 0, 16);
    queue_cmd(CMD_READ_KEY, 0, 0, 0);
    queue_cmd(CMD_READ_KEY, 12345, 0, 0);
    queue_cmd(CMD_RM_KEY, 0, 0, 0);
    queue_cmd(CMD_READ_KEY, 0, 0, 0);
    queue_cmd(CMD_RM_FRONT, 0, 0, 0);
    queue_cmd(CMD_READ_POS, 0, 0, 16);
    wait_drained();

    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7FFF_FFFF;
    key_pool[2] = 0;
    key_pool[3] = -1;
    for (int i = 4; i < 12; i++) key_pool[i] = $urandom();

    // random phase: blocks alternate between filling, draining and balanced mixes
    for (int b = 0; b < 25; b++) begin
      ins_pct = (b % 3 == 0) ? 80 : ((b % 3 == 1) ? 25 : 50);
      for (int j = 0; j < 50; j++) begin
        roll = $urandom_range(0, 99);
        c.cmd = (roll < ins_pct) ? cmd_t'($urandom_range(0, 2)) : cmd_t'($urandom_range(3, 7));
        roll = $urandom_range(0, 99);
        if (roll < 10) key_pool[$urandom_range(0, 11)] = $urandom();
        if (roll < 65) c.key = key_pool[$urandom_range(0, 11)];
        else if (roll < 75) c.key = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else c.key = $urandom();
        c.payload = $urandom();
        c.position = 5'($urandom_range(0, 16));
        queue_cmd(c.cmd, c.key, c.payload, c.position);
      end
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
